FILE: src/anc_pkg.sv
// Shared types and constants for the nibble ADPCM codec.
// Command and status structs between controller and datapath, step scale table.
// No dependencies.
package anc_pkg;

    localparam logic [14:0] STEP_MIN   = 15'd127;
    localparam logic [14:0] STEP_MAX   = 15'd24576;
    localparam logic [14:0] DIFF_MAX   = 15'h7fff;
    localparam logic [9:0]  DECAY_MULT = 10'd254;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // Datapath commands, one step per cycle unless emit waits on a stalled output
    typedef struct packed {
        logic       load_in;
        logic       decay;
        logic       sub;
        logic       div;
        logic [1:0] div_idx;
        logic       mul;
        logic       upd;
        logic       emit;
        logic       nib_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic pend;
    } dp_status_t;

    function automatic logic [9:0] scale_of(input logic [2:0] mag);
        logic [9:0] s;
        unique case (mag)
            3'd4:    s = 10'd307;
            3'd5:    s = 10'd409;
            3'd6:    s = 10'd512;
            3'd7:    s = 10'd614;
            default: s = 10'd230;
        endcase
        return s;
    endfunction

endpackage

FILE: src/anc_ctrl.sv
// Controller FSM for the nibble ADPCM codec; owns the output valid flag.
// Sequences decay, subtract, divide, multiply, update and emit steps.
// Depends on anc_pkg.
module anc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  anc_pkg::dp_status_t status,
    output anc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECAY,
        S_SUB,
        S_DIV,
        S_MUL,
        S_UPD,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       nib_sel_reg, nib_sel_next;
    logic [1:0] div_cnt_reg, div_cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_acc;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        nib_sel_next   = nib_sel_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.nib_sel    = nib_sel_reg;
        cmd.div_idx    = div_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_acc;
                if (in_acc)
                begin
                    nib_sel_next = 1'b0;
                    state_next   = (status.mode == anc_pkg::MODE_ENCODE) ? S_SUB : S_DECAY;
                end
            end
            S_DECAY:
            begin
                cmd.decay  = 1'b1;
                state_next = S_MUL;
            end
            S_SUB:
            begin
                cmd.sub      = 1'b1;
                div_cnt_next = 2'd0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div      = 1'b1;
                div_cnt_next = div_cnt_reg + 2'd1;
                if (div_cnt_reg == 2'd3)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                // encode: only the second sample of a pair gives a byte
                if (status.mode == anc_pkg::MODE_ENCODE && !status.pend)
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.mode == anc_pkg::MODE_ENCODE || nib_sel_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        nib_sel_next = 1'b1;
                        state_next   = S_DECAY;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nib_sel_reg   <= 1'b0;
            div_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nib_sel_reg   <= nib_sel_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/anc_dp.sv
// Datapath for the nibble ADPCM codec: predictor, step size, restoring divider,
// pending nibble and output payload registers. Depends on anc_pkg.
module anc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic [7:0]          code_byte,
    input  logic signed [15:0]  pcm_in,
    input  anc_pkg::dp_cmd_t    cmd,
    output anc_pkg::dp_status_t status,
    output logic signed [15:0]  pcm_out,
    output logic [7:0]          code_out,
    output logic                result_kind,
    output logic                last
);

    // state
    logic               mode_reg;
    logic [14:0]        step_reg, step_next;
    logic signed [15:0] pred_reg, pred_next;
    logic               pend_reg;
    logic [3:0]         pcode_reg;

    // working registers
    logic [7:0]         byte_reg;
    logic signed [15:0] samp_reg;
    logic [3:0]         code_reg;
    logic [17:0]        rem_reg;
    logic [2:0]         q_reg;
    logic               sat_reg;
    logic               neg_reg;
    logic [18:0]        dprod_reg;
    logic [24:0]        sprod_reg;

    logic signed [15:0] pcm_out_reg;
    logic [7:0]         code_out_reg;
    logic               kind_reg;
    logic               last_reg;

    logic signed [24:0] decay_prod;
    logic signed [24:0] decay_adj;
    logic signed [15:0] decay_val;
    logic signed [16:0] diff_s;
    logic [16:0]        abs_d;
    logic [17:0]        div_cmp;
    logic [3:0]         cur_code;
    logic [14:0]        diff15;
    logic [16:0]        pred_ext;
    logic [16:0]        nv;
    logic [16:0]        ns;

    assign status.mode = mode_reg;
    assign status.pend = pend_reg;

    // prediction * 254 / 256, rounded toward zero
    assign decay_prod = pred_reg * $signed({1'b0, anc_pkg::DECAY_MULT});
    assign decay_adj  = decay_prod + (decay_prod[24] ? 25'sd255 : 25'sd0);
    assign decay_val  = decay_adj[23:8];

    assign diff_s = {samp_reg[15], samp_reg} - {pred_reg[15], pred_reg};
    assign abs_d  = diff_s[16] ? (17'd0 - diff_s) : diff_s;

    always_comb
    begin
        unique case (cmd.div_idx)
            2'd0: div_cmp = {step_reg, 3'b000};
            2'd1: div_cmp = {1'b0, step_reg, 2'b00};
            2'd2: div_cmp = {2'b00, step_reg, 1'b0};
            2'd3: div_cmp = {3'b000, step_reg};
            default: div_cmp = {3'b000, step_reg};
        endcase
    end

    always_comb
    begin
        if (mode_reg == anc_pkg::MODE_ENCODE)
            cur_code = {neg_reg, sat_reg ? 3'd7 : q_reg};
        else
            cur_code = cmd.nib_sel ? byte_reg[7:4] : byte_reg[3:0];
    end

    // predictor and step update from registered products
    assign diff15   = dprod_reg[18] ? anc_pkg::DIFF_MAX : dprod_reg[17:3];
    assign pred_ext = {pred_reg[15], pred_reg};
    assign nv       = code_reg[3] ? (pred_ext - {2'b00, diff15})
                                  : (pred_ext + {2'b00, diff15});
    assign ns       = sprod_reg[24:8];

    always_comb
    begin
        if (nv[16] == nv[15])
            pred_next = nv[15:0];
        else if (nv[16])
            pred_next = 16'sh8000;
        else
            pred_next = 16'sh7fff;
        priority if (ns < {2'b00, anc_pkg::STEP_MIN})
            step_next = anc_pkg::STEP_MIN;
        else if (ns > {2'b00, anc_pkg::STEP_MAX})
            step_next = anc_pkg::STEP_MAX;
        else
            step_next = ns[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= anc_pkg::MODE_DECODE;
            step_reg  <= anc_pkg::STEP_MIN;
            pred_reg  <= 16'sd0;
            pend_reg  <= 1'b0;
            pcode_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            mode_reg  <= cfg_data;
            step_reg  <= anc_pkg::STEP_MIN;
            pred_reg  <= 16'sd0;
            pend_reg  <= 1'b0;
            pcode_reg <= 4'd0;
        end
        else if (cmd.decay)
            pred_reg <= decay_val;
        else if (cmd.upd)
        begin
            pred_reg <= pred_next;
            step_reg <= step_next;
            if (mode_reg == anc_pkg::MODE_ENCODE)
            begin
                pend_reg  <= !pend_reg;
                pcode_reg <= pend_reg ? 4'd0 : code_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            byte_reg <= code_byte;
            samp_reg <= {pcm_in[15:3], 3'b000};
        end
        if (cmd.sub)
        begin
            neg_reg <= diff_s[16];
            rem_reg <= {abs_d[15:0], 2'b00};
            q_reg   <= 3'd0;
            sat_reg <= 1'b0;
        end
        if (cmd.div && rem_reg >= div_cmp)
        begin
            // first pass only flags quotient overflow
            unique case (cmd.div_idx)
                2'd0: sat_reg <= 1'b1;
                2'd1: q_reg[2] <= 1'b1;
                2'd2: q_reg[1] <= 1'b1;
                2'd3: q_reg[0] <= 1'b1;
                default: sat_reg <= 1'b1;
            endcase
            if (cmd.div_idx != 2'd0)
                rem_reg <= rem_reg - div_cmp;
        end
        if (cmd.mul)
        begin
            code_reg  <= cur_code;
            dprod_reg <= {cur_code[2:0], 1'b1} * step_reg;
            sprod_reg <= anc_pkg::scale_of(cur_code[2:0]) * step_reg;
        end
        // second encoded nibble completes the byte
        if (cmd.upd && mode_reg == anc_pkg::MODE_ENCODE && pend_reg)
            byte_reg <= {code_reg, pcode_reg};
        if (cmd.emit)
        begin
            kind_reg <= mode_reg;
            last_reg <= (mode_reg == anc_pkg::MODE_ENCODE) || cmd.nib_sel;
            if (mode_reg == anc_pkg::MODE_ENCODE)
            begin
                pcm_out_reg  <= 16'sd0;
                code_out_reg <= byte_reg;
            end
            else
            begin
                pcm_out_reg  <= pred_reg;
                code_out_reg <= 8'd0;
            end
        end
    end

    assign pcm_out     = pcm_out_reg;
    assign code_out    = code_out_reg;
    assign result_kind = kind_reg;
    assign last        = last_reg;

endmodule

FILE: src/adpcm_nibble_codec.sv
// Top level of the 4-bit ADPCM codec with decode and encode modes.
// Instantiates anc_ctrl and anc_dp; depends on anc_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries code_byte in decode mode and
//   pcm_in in encode mode. Output channel (out_valid/out_stall) carries
//   pcm_out, code_out, result_kind and last.
//   cfg_write/cfg_data sets the mode and resets step size, prediction and any
//   half-built code byte; write only while the block is idle.
//   Decode: one byte gives two samples, low nibble first, last on the second.
//   Each nibble runs decay, multiply, update and emit steps, and the sample
//   is loaded into the output register by the emit step.
//   Encode: subtract, a 4-step restoring divide for the code magnitude,
//   multiply and update, and an emit step when the second sample of a pair
//   completes its code byte.
//   The FSM handles one beat at a time; in_stall is high while it works.
//   Results sit in an output register, so the next beat is taken while the
//   last result of the previous one still waits. If the receiver stalls with
//   a result held and another is ready, the FSM waits in its emit step.
//   Reset: decode mode, step size 127, prediction 0, output empty.
module adpcm_nibble_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         code_byte,
    input  logic signed [15:0] pcm_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pcm_out,
    output logic [7:0]         code_out,
    output logic               result_kind,
    output logic               last
);

    anc_pkg::dp_cmd_t    cmd;
    anc_pkg::dp_status_t status;

    anc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    anc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .code_byte   (code_byte),
        .pcm_in      (pcm_in),
        .cmd         (cmd),
        .status      (status),
        .pcm_out     (pcm_out),
        .code_out    (code_out),
        .result_kind (result_kind),
        .last        (last)
    );

endmodule

FILE: src/anc_checker.sv
// Port-level checks for adpcm_nibble_codec, attached with a bind statement.
// No dependencies beyond the top level's ports.
module anc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] pcm_out,
    input logic [7:0]         code_out,
    input logic               result_kind,
    input logic               last
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pcm_out) && $stable(code_out)
            && $stable(result_kind) && $stable(last))
        else $error("stalled output beat changed");

    // an accepted beat keeps the FSM busy; no beat is taken again at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input accepted again too soon");

    // an encoded byte is always the only and last result of its beat
    a_enc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> last && pcm_out == 16'sd0)
        else $error("encoded byte beat malformed");

    a_dec_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> code_out == 8'd0)
        else $error("decoded sample beat carries a code byte");

    // out_valid does not rise again at once after a byte's first result
    a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !result_kind && !last |=> !$rose(out_valid))
        else $error("decoded samples too close");

endmodule

bind adpcm_nibble_codec anc_checker u_anc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pcm_out     (pcm_out),
    .code_out    (code_out),
    .result_kind (result_kind),
    .last        (last)
);

FILE: sim/tb.sv
// Self-checking bench for adpcm_nibble_codec: decode and encode modes, random handshakes.
// Holds its own bit-exact codec predictor and checks every output beat against it.
// Depends on anc_pkg and the adpcm_nibble_codec RTL.
module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0]         code;
        logic signed [15:0] pcm;
    } in_beat_t;

    typedef struct {
        logic signed [15:0] pcm;
        logic [7:0]         code;
        logic               kind;
        logic               last_flag;
    } codec_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         code_byte;
    logic signed [15:0] pcm_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] pcm_out;
    logic [7:0]         code_out;
    logic               result_kind;
    logic               last;

    in_beat_t      input_backlog[$];
    in_beat_t      next_beat;
    codec_result_t due_outputs[$];

    // predictor state
    logic       mode_q;
    int         step_sz;
    int         pred_val;
    logic       half_pend;
    logic [3:0] held_code;
    int         scale_lut[8];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          fail_cnt;
    int          cycle_cnt;

    adpcm_nibble_codec DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_byte   (code_byte),
        .pcm_in      (pcm_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pcm_out     (pcm_out),
        .code_out    (code_out),
        .result_kind (result_kind),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Apply one 4-bit code: move the prediction and rescale the step.
    function automatic logic signed [15:0] adapt(input logic [3:0] code);
        int mag;
        int diff;
        int nv;
        int ns;
        mag = code[2:0];
        diff = ((1 + 2 * mag) * step_sz) >> 3;
        if (diff > 32767)
            diff = 32767;
        nv = code[3] ? pred_val - diff : pred_val + diff;
        ns = (scale_lut[mag] * step_sz) >> 8;
        if (ns < int'(anc_pkg::STEP_MIN))
            ns = anc_pkg::STEP_MIN;
        if (ns > int'(anc_pkg::STEP_MAX))
            ns = anc_pkg::STEP_MAX;
        if (nv > 32767)
            nv = 32767;
        if (nv < -32768)
            nv = -32768;
        step_sz = ns;
        pred_val = nv;
        return nv[15:0];
    endfunction

    function automatic void run_codec(input logic [7:0] cb, input logic signed [15:0] pcm);
        codec_result_t r;
        int s;
        int d;
        int a;
        int mag;
        logic [3:0] code;
        if (mode_q == anc_pkg::MODE_DECODE)
        begin
            for (int n = 0; n < 2; n++)
            begin
                pred_val = (pred_val * 254) / 256;
                r.pcm = adapt(n == 0 ? cb[3:0] : cb[7:4]);
                r.code = 8'h00;
                r.kind = 1'b0;
                r.last_flag = (n == 1);
                due_outputs.push_back(r);
            end
        end
        else
        begin
            s = $signed({pcm[15:3], 3'b000});
            d = s - pred_val;
            a = (d < 0) ? -d : d;
            mag = (a * 4) / step_sz;
            if (mag > 7)
                mag = 7;
            code = {d < 0, mag[2:0]};
            void'(adapt(code));
            if (!half_pend)
            begin
                held_code = code;
                half_pend = 1'b1;
            end
            else
            begin
                r.pcm = 16'sd0;
                r.code = {code, held_code};
                r.kind = 1'b1;
                r.last_flag = 1'b1;
                due_outputs.push_back(r);
                held_code = 4'h0;
                half_pend = 1'b0;
            end
        end
    endfunction

    // Sender: payload holds while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            code_byte <= 8'h00;
            pcm_in <= 16'sd0;
        end
        else
        begin
            if (in_valid && !in_stall)
                run_codec(code_byte, pcm_in);
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (input_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_beat = input_backlog.pop_front();
                code_byte <= next_beat.code;
                pcm_in <= next_beat.pcm;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with an occasional long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_served <= 0;
            hold_left <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_outputs.size() == 0)
            begin
                $error("unexpected output beat: pcm_out=%0d code_out=%h", pcm_out, code_out);
                fail_cnt++;
            end
            else
            begin
                codec_result_t e;
                e = due_outputs.pop_front();
                if (pcm_out !== e.pcm)
                begin
                    $error("pcm_out: expected %0d, got %0d", e.pcm, pcm_out);
                    fail_cnt++;
                end
                if (code_out !== e.code)
                begin
                    $error("code_out: expected %h, got %h", e.code, code_out);
                    fail_cnt++;
                end
                if (result_kind !== e.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
                    fail_cnt++;
                end
                if (last !== e.last_flag)
                begin
                    $error("last: expected %0d, got %0d", e.last_flag, last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mode write also resets step, prediction and any half-built byte.
    task automatic set_mode(input logic m);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_q = m;
        step_sz = anc_pkg::STEP_MIN;
        pred_val = 0;
        half_pend = 1'b0;
        held_code = 4'h0;
    endtask

    // Wait until every beat is taken and every result is back, then let the FSM go quiet.
    task automatic settle();
        @(negedge clk);
        while (input_backlog.size() != 0 || in_valid || due_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_beat(input logic [7:0] cb, input logic signed [15:0] pcm);
        in_beat_t b;
        b.code = cb;
        b.pcm = pcm;
        input_backlog.push_back(b);
    endtask

    task automatic load_segment(input logic m, input int count);
        int s;
        int span;
        int unsigned pick;
        logic signed [15:0] walk;
        walk = 16'sd0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(9);
            if (m == anc_pkg::MODE_DECODE)
            begin
                // small magnitudes now and then keep the step from pinning at max
                if (pick < 7)
                    push_beat(8'($urandom), 16'($urandom));
                else
                    push_beat(8'($urandom) & 8'hBB, 16'($urandom));
            end
            else
            begin
                if (pick < 6)
                begin
                    span = 1 << $urandom_range(3, 12);
                    s = int'(walk) + int'($urandom_range(0, 2 * span)) - span;
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                    walk = s[15:0];
                end
                else if (pick < 8)
                    walk = 16'($urandom);
                else if (pick == 8)
                    walk = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                push_beat(8'($urandom), walk);
            end
        end
    endtask

    initial
    begin
        scale_lut = '{230, 230, 230, 230, 307, 409, 512, 614};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        fail_cnt = 0;
        mode_q = anc_pkg::MODE_DECODE;
        step_sz = anc_pkg::STEP_MIN;
        pred_val = 0;
        half_pend = 1'b0;
        held_code = 4'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // decode: climb to max step and positive saturation, swing to negative,
        // then decay and sign-only codes
        repeat (5) push_beat(8'h77, 16'($urandom));
        repeat (5) push_beat(8'hFF, 16'($urandom));
        push_beat(8'h00, 16'sh7fff);
        push_beat(8'h88, 16'sh8000);
        push_beat(8'h08, 16'($urandom));
        push_beat(8'hF0, 16'($urandom));
        settle();

        // encode: full-scale swings, masked low bits, odd count leaves a half byte
        set_mode(anc_pkg::MODE_ENCODE);
        push_beat(8'hFF, 16'sh7fff);
        push_beat(8'h00, 16'sh7fff);
        repeat (4) push_beat(8'($urandom), 16'sh8000);
        push_beat(8'($urandom), 16'sd7);
        push_beat(8'($urandom), -16'sd1);
        push_beat(8'($urandom), -16'sd8);
        push_beat(8'($urandom), -16'sd9);
        push_beat(8'($urandom), 16'sd5);
        settle();
        // same mode again drops the pending nibble
        set_mode(anc_pkg::MODE_ENCODE);

        for (int prof = 0; prof < 3; prof++)
        begin
            unique case (prof)
                0:
                begin
                    idle_pct = 38;
                    stall_pct = 64;
                end
                1:
                begin
                    idle_pct = 64;
                    stall_pct = 38;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            for (int mi = 0; mi < 2; mi++)
            begin
                set_mode(mi == 0 ? anc_pkg::MODE_DECODE : anc_pkg::MODE_ENCODE);
                load_segment(mi == 0 ? anc_pkg::MODE_DECODE : anc_pkg::MODE_ENCODE,
                             300 + $urandom_range(0, 60));
                if (mi == prof % 2)
                begin
                    repeat (30) @(posedge clk);
                    hold_requests++;
                end
                settle();
            end
        end

        if (due_outputs.size() != 0)
        begin
            $error("%0d expected results never arrived", due_outputs.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
src/anc_pkg.sv
src/anc_ctrl.sv
src/anc_dp.sv
src/adpcm_nibble_codec.sv
src/anc_checker.sv
sim/tb.sv
